// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/a64srf_pkg.sv =====
package a64srf_pkg;

    localparam int DataW = 64;
    localparam int IdW   = 16;
    localparam int GenW  = 32;
    localparam int CfgIdxW = 2;

    localparam logic [IdW-1:0] R_MIDR      = 16'hC000;
    localparam logic [IdW-1:0] R_MPIDR     = 16'hC005;
    localparam logic [IdW-1:0] R_REVIDR    = 16'hC006;
    localparam logic [IdW-1:0] R_CURRENTEL = 16'hC212;
    localparam logic [IdW-1:0] R_CTR       = 16'hD801;
    localparam logic [IdW-1:0] R_DCZID     = 16'hD807;
    localparam logic [IdW-1:0] R_SCTLR     = 16'hC080;
    localparam logic [IdW-1:0] R_CPACR     = 16'hC082;
    localparam logic [IdW-1:0] R_TTBR0     = 16'hC100;
    localparam logic [IdW-1:0] R_TTBR1     = 16'hC101;
    localparam logic [IdW-1:0] R_TCR       = 16'hC102;
    localparam logic [IdW-1:0] R_MAIR      = 16'hC510;
    localparam logic [IdW-1:0] R_VBAR      = 16'hC600;
    localparam logic [IdW-1:0] R_ESR       = 16'hC290;
    localparam logic [IdW-1:0] R_FAR       = 16'hC300;
    localparam logic [IdW-1:0] R_ELR       = 16'hC201;
    localparam logic [IdW-1:0] R_SPSR      = 16'hC200;
    localparam logic [IdW-1:0] R_SPEL0     = 16'hC208;
    localparam logic [IdW-1:0] R_NZCV      = 16'hDA10;
    localparam logic [IdW-1:0] R_DAIF      = 16'hDA11;
    localparam logic [IdW-1:0] R_SPSEL     = 16'hC210;
    localparam logic [IdW-1:0] R_TPIDR0    = 16'hDE82;
    localparam logic [IdW-1:0] R_TPIDRRO0  = 16'hDE83;
    localparam logic [IdW-1:0] R_TPIDR1    = 16'hC684;
    localparam logic [IdW-1:0] R_CONTEXTID = 16'hC681;
    localparam logic [IdW-1:0] R_CNTFRQ    = 16'hDF00;
    localparam logic [IdW-1:0] R_CNTPCT    = 16'hDF01;
    localparam logic [IdW-1:0] R_CNTVCT    = 16'hDF02;
    localparam logic [IdW-1:0] R_PTVAL     = 16'hDF10;
    localparam logic [IdW-1:0] R_PCTL      = 16'hDF11;
    localparam logic [IdW-1:0] R_PCVAL     = 16'hDF12;
    localparam logic [IdW-1:0] R_VTVAL     = 16'hDF18;
    localparam logic [IdW-1:0] R_VCTL      = 16'hDF19;
    localparam logic [IdW-1:0] R_VCVAL     = 16'hDF1A;

    localparam logic [DataW-1:0] CTR_VALUE   = 64'h0000_0000_8444_C004;
    localparam logic [DataW-1:0] DCZID_VALUE = 64'h4;
    localparam logic [DataW-1:0] VBAR_MASK   = ~64'h7FF;

    localparam logic [CfgIdxW-1:0] CFG_MAIN_ID     = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_AFFINITY_ID = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_REVISION_ID = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_VIRT_OFFSET = 2'd3;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_kind_t;

    // Registered access request.
    typedef struct packed {
        logic             wr;
        logic [IdW-1:0]   reg_id;
        logic [DataW-1:0] wdata;
        logic [1:0]       el;
        logic [DataW-1:0] count;
    } req_t;

    function automatic logic [DataW-1:0] sext32(input logic [DataW-1:0] v);
        sext32 = {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic el0_allowed(input logic [IdW-1:0] id, input logic wr);
        el0_allowed = 1'b0;
        if (id == R_NZCV || id == R_TPIDR0) begin
            el0_allowed = 1'b1;
        end else if (id == R_TPIDRRO0 || id == R_CNTFRQ || id == R_CNTPCT
                || id == R_CNTVCT || id == R_CTR || id == R_DCZID) begin
            el0_allowed = !wr;
        end
    endfunction

endpackage

// ===== hdl/a64srf_regs.sv =====
module a64srf_regs (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    req_valid,
    input  a64srf_pkg::req_t                        req,
    input  logic [a64srf_pkg::DataW-1:0]            main_id,
    input  logic [a64srf_pkg::DataW-1:0]            affinity_id,
    input  logic [a64srf_pkg::DataW-1:0]            revision_id,
    input  logic [a64srf_pkg::DataW-1:0]            virtual_offset,
    output logic [a64srf_pkg::DataW-1:0]            rd_data,
    output logic                                    rd_ok,
    output logic [a64srf_pkg::GenW-1:0]             gen_next,
    output logic                                    bump
);
    import a64srf_pkg::*;

    logic [DataW-1:0] sctlr_reg, cpacr_reg, ttbr0_reg, ttbr1_reg, tcr_reg, mair_reg;
    logic [DataW-1:0] vbar_reg, esr_reg, far_reg, elr_reg, spsr_reg, spel0_reg;
    logic [3:0]       nzcv_reg, daif_reg;
    logic             spsel_reg;
    logic [DataW-1:0] tpidr0_reg, tpidrro_reg, tpidr1_reg, ctxid_reg, cntfrq_reg;
    logic [1:0]       pctl_reg, vctl_reg;
    logic [DataW-1:0] pcval_reg, vcval_reg;
    logic [GenW-1:0]  gen_reg;

    logic [DataW-1:0] vcount, pdiff, vdiff, rdv;
    logic             allowed, known, wr_ok, pfire, vfire;

    always_comb begin
        vcount = req.count - virtual_offset;
        pdiff  = pcval_reg - req.count;
        vdiff  = vcval_reg - vcount;
        pfire  = pctl_reg[0] && (req.count >= pcval_reg);
        vfire  = vctl_reg[0] && (vcount >= vcval_reg);
        allowed = (req.el != 2'd0) || el0_allowed(req.reg_id, req.wr);
        known = 1'b1;
        rdv   = '0;
        unique case (req.reg_id)
            R_MIDR:      rdv = main_id;
            R_MPIDR:     rdv = affinity_id;
            R_REVIDR:    rdv = revision_id;
            R_CURRENTEL: rdv = {60'd0, req.el, 2'b00};
            R_CTR:       rdv = CTR_VALUE;
            R_DCZID:     rdv = DCZID_VALUE;
            R_SCTLR:     rdv = sctlr_reg;
            R_CPACR:     rdv = cpacr_reg;
            R_TTBR0:     rdv = ttbr0_reg;
            R_TTBR1:     rdv = ttbr1_reg;
            R_TCR:       rdv = tcr_reg;
            R_MAIR:      rdv = mair_reg;
            R_VBAR:      rdv = vbar_reg;
            R_ESR:       rdv = esr_reg;
            R_FAR:       rdv = far_reg;
            R_ELR:       rdv = elr_reg;
            R_SPSR:      rdv = spsr_reg;
            R_SPEL0:     rdv = spel0_reg;
            R_NZCV:      rdv = {32'd0, nzcv_reg, 28'd0};
            R_DAIF:      rdv = {54'd0, daif_reg, 6'd0};
            R_SPSEL:     rdv = {63'd0, spsel_reg};
            R_TPIDR0:    rdv = tpidr0_reg;
            R_TPIDRRO0:  rdv = tpidrro_reg;
            R_TPIDR1:    rdv = tpidr1_reg;
            R_CONTEXTID: rdv = ctxid_reg;
            R_CNTFRQ:    rdv = cntfrq_reg;
            R_CNTPCT:    rdv = req.count;
            R_CNTVCT:    rdv = vcount;
            R_PCTL:      rdv = {61'd0, pfire, pctl_reg};
            R_PCVAL:     rdv = pcval_reg;
            R_PTVAL:     rdv = sext32(pdiff);
            R_VCTL:      rdv = {61'd0, vfire, vctl_reg};
            R_VCVAL:     rdv = vcval_reg;
            R_VTVAL:     rdv = sext32(vdiff);
            default:     known = 1'b0;
        endcase
        // read-only registers refuse writes
        wr_ok = known && !(req.reg_id == R_MIDR || req.reg_id == R_MPIDR
            || req.reg_id == R_REVIDR || req.reg_id == R_CURRENTEL
            || req.reg_id == R_CNTPCT || req.reg_id == R_CNTVCT
            || req.reg_id == R_CTR || req.reg_id == R_DCZID);
        rd_ok   = allowed && (req.wr ? wr_ok : known);
        rd_data = (rd_ok && !req.wr) ? rdv : '0;
        bump = rd_ok && req.wr && (req.reg_id == R_SCTLR || req.reg_id == R_TTBR0
            || req.reg_id == R_TTBR1 || req.reg_id == R_TCR || req.reg_id == R_MAIR);
        gen_next = gen_reg + GenW'(bump);
    end

    logic we;
    assign we = req_valid && rd_ok && req.wr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sctlr_reg <= '0; cpacr_reg <= '0; ttbr0_reg <= '0; ttbr1_reg <= '0;
            tcr_reg <= '0; mair_reg <= '0; vbar_reg <= '0; esr_reg <= '0;
            far_reg <= '0; elr_reg <= '0; spsr_reg <= '0; spel0_reg <= '0;
            nzcv_reg <= '0; daif_reg <= '0; spsel_reg <= 1'b0;
            tpidr0_reg <= '0; tpidrro_reg <= '0; tpidr1_reg <= '0; ctxid_reg <= '0;
            cntfrq_reg <= '0; pctl_reg <= '0; vctl_reg <= '0;
            pcval_reg <= '0; vcval_reg <= '0; gen_reg <= '0;
        end else if (we) begin
            gen_reg <= gen_next;
            unique case (req.reg_id)
                R_SCTLR:     sctlr_reg <= req.wdata;
                R_CPACR:     cpacr_reg <= req.wdata;
                R_TTBR0:     ttbr0_reg <= req.wdata;
                R_TTBR1:     ttbr1_reg <= req.wdata;
                R_TCR:       tcr_reg <= req.wdata;
                R_MAIR:      mair_reg <= req.wdata;
                R_VBAR:      vbar_reg <= req.wdata & VBAR_MASK;
                R_ESR:       esr_reg <= req.wdata;
                R_FAR:       far_reg <= req.wdata;
                R_ELR:       elr_reg <= req.wdata;
                R_SPSR:      spsr_reg <= req.wdata;
                R_SPEL0:     spel0_reg <= req.wdata;
                R_NZCV:      nzcv_reg <= req.wdata[31:28];
                R_DAIF:      daif_reg <= req.wdata[9:6];
                R_SPSEL:     spsel_reg <= req.wdata[0];
                R_TPIDR0:    tpidr0_reg <= req.wdata;
                R_TPIDRRO0:  tpidrro_reg <= req.wdata;
                R_TPIDR1:    tpidr1_reg <= req.wdata;
                R_CONTEXTID: ctxid_reg <= req.wdata;
                R_CNTFRQ:    cntfrq_reg <= req.wdata;
                R_PCTL:      pctl_reg <= req.wdata[1:0];
                R_PCVAL:     pcval_reg <= req.wdata;
                R_PTVAL:     pcval_reg <= req.count + sext32(req.wdata);
                R_VCTL:      vctl_reg <= req.wdata[1:0];
                R_VCVAL:     vcval_reg <= req.wdata;
                R_VTVAL:     vcval_reg <= vcount + sext32(req.wdata);
                default:     ;
            endcase
        end
    end

endmodule

// ===== hdl/aarch64_system_register_file_core.sv =====
// System register file with generic timer.
// Input channel s_*: one register access request (op, reg_id, write_data,
// exception_level, counter_value), valid/ready handshake.
// Result channel m_*: read_data, ok, translation_generation and
// translation_changed for each request, in order.
// Config channel cfg_*: cfg_index 0..3 selects main_id, affinity_id,
// revision_id, virtual_offset; write only while the block is idle.
// A request is captured in an input register when it is accepted, decoded
// and executed combinationally from that register, and its result lands in
// the output register when that register is free or being drained, which
// raises m_valid.
// Throughput is one request per cycle while the receiver does not stall, set
// by the single decode/subtract/compare stage; state writes commit as the
// request moves into the output register, so the next request sees them.
// Reset (aresetn low, synchronous) clears all but the request/result data.
// When the receiver stalls, the output register holds, the stage behind it
// holds, and s_ready drops once both are full.
module aarch64_system_register_file_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [a64srf_pkg::IdW-1:0]        s_reg_id,
    input  logic [a64srf_pkg::DataW-1:0]      s_write_data,
    input  logic [1:0]                        s_exception_level,
    input  logic [a64srf_pkg::DataW-1:0]      s_counter_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [a64srf_pkg::DataW-1:0]      m_read_data,
    output logic                              m_ok,
    output logic [a64srf_pkg::GenW-1:0]       m_translation_generation,
    output logic                              m_translation_changed,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [a64srf_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [a64srf_pkg::DataW-1:0]      cfg_data
);
    import a64srf_pkg::*;

    logic [DataW-1:0] main_id_reg, affinity_id_reg, revision_id_reg, voff_reg;
    req_t             req_reg;
    logic             req_valid_reg;
    logic             adv;
    logic [DataW-1:0] rd_data;
    logic             rd_ok, bump;
    logic [GenW-1:0]  gen_next;

    assign cfg_ready = 1'b1;

    // advance the stage when the output register is free or being drained
    assign adv     = !m_valid || m_ready;
    assign s_ready = !req_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_id_reg <= '0; affinity_id_reg <= '0;
            revision_id_reg <= '0; voff_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAIN_ID:     main_id_reg <= cfg_data;
                CFG_AFFINITY_ID: affinity_id_reg <= cfg_data;
                CFG_REVISION_ID: revision_id_reg <= cfg_data;
                CFG_VIRT_OFFSET: voff_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            req_reg.wr     <= (s_op == OP_WRITE);
            req_reg.reg_id <= s_reg_id;
            req_reg.wdata  <= s_write_data;
            req_reg.el     <= s_exception_level;
            req_reg.count  <= s_counter_value;
        end
    end

    a64srf_regs u_regs (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req_valid      (req_valid_reg && adv),
        .req            (req_reg),
        .main_id        (main_id_reg),
        .affinity_id    (affinity_id_reg),
        .revision_id    (revision_id_reg),
        .virtual_offset (voff_reg),
        .rd_data        (rd_data),
        .rd_ok          (rd_ok),
        .gen_next       (gen_next),
        .bump           (bump)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (adv) begin
            m_valid <= req_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && req_valid_reg) begin
            m_read_data              <= rd_data;
            m_ok                     <= rd_ok;
            m_translation_generation <= gen_next;
            m_translation_changed    <= bump;
        end
    end

endmodule

// ===== hdl/a64srf_checker.sv =====
`include "assert_macros.svh"

module a64srf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_ok,
    input logic [63:0] m_read_data,
    input logic        m_translation_changed,
    input logic [31:0] m_translation_generation
);
    `ASSERT_IMPL(a_fail_zero, aclk, aresetn, m_valid && !m_ok, m_read_data == 64'd0)
    `ASSERT_IMPL(a_bump_ok, aclk, aresetn, m_valid && m_translation_changed, m_ok)
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_read_data))
    `ASSERT_IMPL(a_ready_free, aclk, aresetn, !m_valid, s_ready)
endmodule

bind aarch64_system_register_file_core a64srf_checker u_chk (.*);

// ===== test/sysreg_checker.sv =====
`timescale 1ns / 100ps

module sysreg_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic                               s_op,
    input  logic [a64srf_pkg::IdW-1:0]         s_reg_id,
    input  logic [a64srf_pkg::DataW-1:0]       s_write_data,
    input  logic [1:0]                         s_exception_level,
    input  logic [a64srf_pkg::DataW-1:0]       s_counter_value,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [a64srf_pkg::DataW-1:0]       m_read_data,
    input  logic                               m_ok,
    input  logic [a64srf_pkg::GenW-1:0]        m_translation_generation,
    input  logic                               m_translation_changed,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [a64srf_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [a64srf_pkg::DataW-1:0]       cfg_data,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 checked
);
    import a64srf_pkg::*;

    typedef struct {
        logic [DataW-1:0] rdata;
        logic             ok;
        logic [GenW-1:0]  gen;
        logic             changed;
    } outcome_t;

    outcome_t expected_q[$];

    logic [DataW-1:0] midr_v, mpidr_v, revidr_v, voff;
    logic [DataW-1:0] sctlr, cpacr, ttbr0, ttbr1, tcr, mair, vbar;
    logic [DataW-1:0] esr, far_v, elr, spsr, sp_el0, cntfrq;
    logic [3:0]       nzcv, daif;
    logic             spsel;
    logic [DataW-1:0] tpidr[4];
    logic [1:0]       pctl, vctl;
    logic [DataW-1:0] pcmp, vcmp;
    logic [GenW-1:0]  gen_count;

    function automatic logic [DataW-1:0] low32_signed(input logic [DataW-1:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic [DataW-1:0] timer_ctl(input logic [1:0] ctl,
            input logic [DataW-1:0] cmp, input logic [DataW-1:0] cnt);
        return {61'd0, ctl[0] && (cnt >= cmp), ctl};
    endfunction

    // Compute the outcome of one access and commit its state change.
    function automatic outcome_t sysreg_access(input logic wr, input logic [IdW-1:0] id,
            input logic [DataW-1:0] d, input logic [1:0] el, input logic [DataW-1:0] pc);
        outcome_t r;
        logic [DataW-1:0] vc;
        logic user_ok;
        vc = pc - voff;
        r.rdata = '0;
        r.ok = 1'b1;
        r.changed = 1'b0;
        user_ok = (id == R_NZCV || id == R_TPIDR0) || (!wr && (id inside
            {R_TPIDRRO0, R_CNTFRQ, R_CNTPCT, R_CNTVCT, R_CTR, R_DCZID}));
        if (el == 2'd0 && !user_ok) begin
            r.ok = 1'b0;
        end else if (wr) begin
            case (id)
                R_SCTLR: begin sctlr = d; r.changed = 1'b1; end
                R_CPACR: cpacr = d;
                R_TTBR0: begin ttbr0 = d; r.changed = 1'b1; end
                R_TTBR1: begin ttbr1 = d; r.changed = 1'b1; end
                R_TCR: begin tcr = d; r.changed = 1'b1; end
                R_MAIR: begin mair = d; r.changed = 1'b1; end
                R_VBAR: vbar = {d[63:11], 11'd0};
                R_ESR: esr = d;
                R_FAR: far_v = d;
                R_ELR: elr = d;
                R_SPSR: spsr = d;
                R_SPEL0: sp_el0 = d;
                R_NZCV: nzcv = d[31:28];
                R_DAIF: daif = d[9:6];
                R_SPSEL: spsel = d[0];
                R_TPIDR0: tpidr[0] = d;
                R_TPIDRRO0: tpidr[1] = d;
                R_TPIDR1: tpidr[2] = d;
                R_CONTEXTID: tpidr[3] = d;
                R_CNTFRQ: cntfrq = d;
                R_PCTL: pctl = d[1:0];
                R_PCVAL: pcmp = d;
                R_PTVAL: pcmp = pc + low32_signed(d);
                R_VCTL: vctl = d[1:0];
                R_VCVAL: vcmp = d;
                R_VTVAL: vcmp = vc + low32_signed(d);
                default: r.ok = 1'b0;
            endcase
        end else begin
            case (id)
                R_MIDR: r.rdata = midr_v;
                R_MPIDR: r.rdata = mpidr_v;
                R_REVIDR: r.rdata = revidr_v;
                R_CURRENTEL: r.rdata = {60'd0, el, 2'd0};
                R_CTR: r.rdata = CTR_VALUE;
                R_DCZID: r.rdata = DCZID_VALUE;
                R_SCTLR: r.rdata = sctlr;
                R_CPACR: r.rdata = cpacr;
                R_TTBR0: r.rdata = ttbr0;
                R_TTBR1: r.rdata = ttbr1;
                R_TCR: r.rdata = tcr;
                R_MAIR: r.rdata = mair;
                R_VBAR: r.rdata = vbar;
                R_ESR: r.rdata = esr;
                R_FAR: r.rdata = far_v;
                R_ELR: r.rdata = elr;
                R_SPSR: r.rdata = spsr;
                R_SPEL0: r.rdata = sp_el0;
                R_NZCV: r.rdata = {32'd0, nzcv, 28'd0};
                R_DAIF: r.rdata = {54'd0, daif, 6'd0};
                R_SPSEL: r.rdata = {63'd0, spsel};
                R_TPIDR0: r.rdata = tpidr[0];
                R_TPIDRRO0: r.rdata = tpidr[1];
                R_TPIDR1: r.rdata = tpidr[2];
                R_CONTEXTID: r.rdata = tpidr[3];
                R_CNTFRQ: r.rdata = cntfrq;
                R_CNTPCT: r.rdata = pc;
                R_CNTVCT: r.rdata = vc;
                R_PCTL: r.rdata = timer_ctl(pctl, pcmp, pc);
                R_PCVAL: r.rdata = pcmp;
                R_PTVAL: r.rdata = low32_signed(pcmp - pc);
                R_VCTL: r.rdata = timer_ctl(vctl, vcmp, vc);
                R_VCVAL: r.rdata = vcmp;
                R_VTVAL: r.rdata = low32_signed(vcmp - vc);
                default: r.ok = 1'b0;
            endcase
        end
        if (r.changed) gen_count = gen_count + 1'b1;
        r.gen = gen_count;
        return r;
    endfunction

    always @(posedge aclk) begin
        outcome_t e;
        if (!aresetn) begin
            expected_q.delete();
            fail_count = 0;
            checked = 0;
            {midr_v, mpidr_v, revidr_v, voff} = '0;
            {sctlr, cpacr, ttbr0, ttbr1, tcr, mair, vbar} = '0;
            {esr, far_v, elr, spsr, sp_el0, cntfrq} = '0;
            {nzcv, daif, spsel, pctl, vctl, pcmp, vcmp, gen_count} = '0;
            foreach (tpidr[i]) tpidr[i] = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MAIN_ID: midr_v = cfg_data;
                    CFG_AFFINITY_ID: mpidr_v = cfg_data;
                    CFG_REVISION_ID: revidr_v = cfg_data;
                    CFG_VIRT_OFFSET: voff = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result rdata=%h ok=%b", $time, m_read_data, m_ok);
                    fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    checked++;
                    if (m_read_data !== e.rdata) begin
                        $display("%0t: read_data exp %h got %h", $time, e.rdata, m_read_data);
                        fail_count++;
                    end
                    if (m_ok !== e.ok) begin
                        $display("%0t: ok exp %b got %b", $time, e.ok, m_ok);
                        fail_count++;
                    end
                    if (m_translation_generation !== e.gen) begin
                        $display("%0t: generation exp %h got %h", $time, e.gen,
                                 m_translation_generation);
                        fail_count++;
                    end
                    if (m_translation_changed !== e.changed) begin
                        $display("%0t: changed exp %b got %b", $time, e.changed,
                                 m_translation_changed);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(sysreg_access(s_op, s_reg_id, s_write_data,
                                                   s_exception_level, s_counter_value));
        end
        pending = expected_q.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import a64srf_pkg::*;

    localparam int CycleLimit = 400000;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_op;
    logic [IdW-1:0]   s_reg_id;
    logic [DataW-1:0] s_write_data;
    logic [1:0]       s_exception_level;
    logic [DataW-1:0] s_counter_value;
    logic             m_valid;
    logic             m_ready;
    logic [DataW-1:0] m_read_data;
    logic             m_ok;
    logic [GenW-1:0]  m_translation_generation;
    logic             m_translation_changed;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CfgIdxW-1:0] cfg_index;
    logic [DataW-1:0] cfg_data;

    int  fail_count, pending, checked;
    int  cycles;
    int  requests_sent;
    bit  no_idle;              // both sides run without gaps while set
    logic [DataW-1:0] count_now;

    // Every register the block knows, for random picks.
    logic [IdW-1:0] known_ids[34] = '{R_MIDR, R_MPIDR, R_REVIDR, R_CURRENTEL, R_CTR,
        R_DCZID, R_SCTLR, R_CPACR, R_TTBR0, R_TTBR1, R_TCR, R_MAIR, R_VBAR, R_ESR,
        R_FAR, R_ELR, R_SPSR, R_SPEL0, R_NZCV, R_DAIF, R_SPSEL, R_TPIDR0, R_TPIDRRO0,
        R_TPIDR1, R_CONTEXTID, R_CNTFRQ, R_CNTPCT, R_CNTVCT, R_PTVAL, R_PCTL, R_PCVAL,
        R_VTVAL, R_VCTL, R_VCVAL};

    aarch64_system_register_file_core i_dut (.*);

    sysreg_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop for a hung handshake.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL aarch64_system_register_file_core");
            $finish;
        end
    end

    // Receiver: randomly stall before taking each result.
    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 3);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Send one request: maybe idle first, then hold it until accepted.
    task automatic send_request(input op_kind_t op, input logic [IdW-1:0] id,
            input logic [DataW-1:0] d, input logic [1:0] el, input logic [DataW-1:0] cnt);
        int n;
        n = no_idle ? 0 : $urandom_range(0, 3);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_reg_id <= id;
        s_write_data <= d;
        s_exception_level <= el;
        s_counter_value <= cnt;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    // Drop valid and wait for every outstanding result, plus pipeline slack.
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_setting(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [DataW-1:0] pick_data();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'h0000_0000_8000_0000;
            3: return 64'h0000_0000_7FFF_FFFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Advance the counter mostly in small steps; sometimes jump anywhere.
    function automatic logic [DataW-1:0] next_count();
        if ($urandom_range(0, 15) == 0) count_now = pick_data();
        else count_now = count_now + $urandom_range(0, 40);
        return count_now;
    endfunction

    initial begin
        logic [IdW-1:0] id;
        logic [1:0] el;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = 1'b0;
        s_reg_id = '0;
        s_write_data = '0;
        s_exception_level = '0;
        s_counter_value = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycles = 0;
        requests_sent = 0;
        no_idle = 1'b0;
        count_now = 64'd1000;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // All-ones main ID and offset, a top-bit affinity, a random revision.
        write_setting(CFG_MAIN_ID, '1);
        write_setting(CFG_AFFINITY_ID, 64'h8000_0000_0000_0001);
        write_setting(CFG_REVISION_ID, {$urandom, $urandom});
        write_setting(CFG_VIRT_OFFSET, '1);

        // Directed: identification, constants, privilege and read-only rules.
        send_request(OP_READ, R_MIDR, '0, 2'd1, 64'd0);
        send_request(OP_READ, R_MPIDR, '0, 2'd3, 64'd0);
        send_request(OP_READ, R_REVIDR, '0, 2'd2, 64'd0);
        send_request(OP_WRITE, R_MIDR, '1, 2'd3, 64'd0);
        send_request(OP_READ, R_CURRENTEL, '0, 2'd3, 64'd0);
        send_request(OP_READ, R_CTR, '0, 2'd0, 64'd0);
        send_request(OP_READ, R_DCZID, '0, 2'd0, 64'd0);
        send_request(OP_WRITE, R_CTR, '1, 2'd1, 64'd0);
        send_request(OP_READ, R_SCTLR, '0, 2'd0, 64'd0);
        send_request(OP_WRITE, R_TPIDRRO0, '1, 2'd0, 64'd0);
        send_request(OP_WRITE, R_NZCV, '1, 2'd0, 64'd0);
        send_request(OP_READ, R_NZCV, '0, 2'd0, 64'd0);
        send_request(OP_WRITE, R_DAIF, '1, 2'd1, 64'd0);
        send_request(OP_READ, R_DAIF, '0, 2'd1, 64'd0);
        send_request(OP_WRITE, R_VBAR, '1, 2'd1, 64'd0);
        send_request(OP_READ, R_VBAR, '0, 2'd2, 64'd0);
        send_request(OP_WRITE, R_TTBR0, '1, 2'd1, 64'd0);
        send_request(OP_WRITE, 16'hFFFF, '1, 2'd3, 64'd0);
        // Timer: TVAL extremes, then enable and fire across counter wrap.
        send_request(OP_WRITE, R_PTVAL, 64'h0000_0000_8000_0000, 2'd1, '1);
        send_request(OP_READ, R_PTVAL, '0, 2'd1, '1);
        send_request(OP_WRITE, R_PCTL, '1, 2'd1, '0);
        send_request(OP_READ, R_PCTL, '0, 2'd1, '1);
        send_request(OP_WRITE, R_VTVAL, 64'h0000_0000_7FFF_FFFF, 2'd1, 64'd5);
        send_request(OP_WRITE, R_VCTL, 64'd1, 2'd1, 64'd5);
        send_request(OP_READ, R_VCTL, '0, 2'd1, 64'd5);
        drain();

        // Random phases, each with its own settings.
        for (int phase = 0; phase < 4; phase++) begin
            write_setting(CFG_MAIN_ID, phase == 0 ? '0 : {$urandom, $urandom});
            write_setting(CFG_AFFINITY_ID, {$urandom, $urandom});
            write_setting(CFG_REVISION_ID, phase == 3 ? '1 : {$urandom, $urandom});
            write_setting(CFG_VIRT_OFFSET, phase == 0 ? '0 : pick_data());
            for (int i = 0; i < 400; i++) begin
                if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
                // Hold off mid-run until the block has delivered everything.
                if (phase == 1 && i == 200) drain();
                id = ($urandom_range(0, 9) == 0) ? IdW'($urandom)
                                                 : known_ids[$urandom_range(0, 33)];
                el = ($urandom_range(0, 4) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
                send_request($urandom_range(0, 1) ? OP_WRITE : OP_READ, id, pick_data(),
                             el, next_count());
            end
            no_idle = 1'b0;
            drain();
        end

        $display("covered %0d requests, %0d results checked, over 5 identification/offset settings",
                 requests_sent, checked);
        if (fail_count == 0) begin
            $display("PASS aarch64_system_register_file_core");
        end else begin
            $display("FAIL aarch64_system_register_file_core");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/a64srf_pkg.sv
hdl/a64srf_regs.sv
hdl/aarch64_system_register_file_core.sv
hdl/a64srf_checker.sv
test/sysreg_checker.sv
test/testbench.sv
